@@ hw/rtl/bootp_crs_pkg.sv @@
`default_nettype none

package bootp_crs_pkg;

    // field widths fixed by the exchange format
    localparam int ACT_W      = 2;
    localparam int JIT_W      = 5;
    localparam int XID_W      = 32;
    localparam int HWT_W      = 8;
    localparam int HWL_W      = 3;
    localparam int RX_HWL_W   = 8;
    localparam int ADDR_W     = 48;
    localparam int HW_BYTES   = 6;
    localparam int TAG_W      = 3;
    localparam int EV_W       = 3;
    localparam int SECS_W     = 16;
    localparam int ATT_W      = 8;
    localparam int GATHER_W   = 16;
    localparam int WAIT_W     = 10;
    localparam int TICKS_W    = 11;
    localparam int SUB_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // ticks per second, minus one, for the seconds prescaler
    localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(10 - 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_START  = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_REPLY  = 2'd2,
        ACT_UNUSED = 2'd3
    } t_action;

    typedef enum logic [EV_W-1:0] {
        EV_NONE          = 3'd0,
        EV_SEND          = 3'd1,
        EV_KEPT          = 3'd2,
        EV_DONE_ANSWERED = 3'd3,
        EV_DONE_TIMEOUT  = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        K_NOP   = 2'd0,
        K_START = 2'd1,
        K_TICK  = 2'd2,
        K_REPLY = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HW_TYPE      = 3'd0,
        CFG_HW_LEN       = 3'd1,
        CFG_HW_ADDR      = 3'd2,
        CFG_RETRY_LIMIT  = 3'd3,
        CFG_GATHER_LIMIT = 3'd4,
        CFG_XID_START    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [HWT_W-1:0]    hw_type;
        logic [HWL_W-1:0]    hw_len;
        logic [ADDR_W-1:0]   hw_addr;
        logic [ATT_W-1:0]    retry_limit;
        logic [GATHER_W-1:0] gather_limit;
        logic [XID_W-1:0]    xid_start;
    } t_cfg;

    // classified request handed from front to back
    typedef struct packed {
        t_kind                    kind;
        logic signed [JIT_W-1:0]  jitter;
        logic [XID_W-1:0]         rx_xid;
        logic                     fields_ok;
        logic [TAG_W-1:0]         tags;
        logic                     complete;
    } t_item;

    typedef struct packed {
        t_event             event_res;
        logic [XID_W-1:0]   xid;
        logic [SECS_W-1:0]  secs;
        logic [ATT_W-1:0]   attempt;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/bootp_crs_if.sv @@
`default_nettype none

interface bootp_crs_in_if;
    logic                                        valid;
    logic                                        ready;
    logic [bootp_crs_pkg::ACT_W-1:0]             action;
    logic signed [bootp_crs_pkg::JIT_W-1:0]      jitter;
    logic [bootp_crs_pkg::XID_W-1:0]             rx_xid;
    logic                                        rx_your_addr_set;
    logic                                        rx_client_addr_set;
    logic [bootp_crs_pkg::HWT_W-1:0]             rx_hw_type;
    logic [bootp_crs_pkg::RX_HWL_W-1:0]          rx_hw_len;
    logic [bootp_crs_pkg::ADDR_W-1:0]            rx_hw_addr;
    logic [bootp_crs_pkg::TAG_W-1:0]             rx_tags;
    logic                                        rx_too_short;

    modport source (
        output valid, action, jitter, rx_xid, rx_your_addr_set, rx_client_addr_set,
               rx_hw_type, rx_hw_len, rx_hw_addr, rx_tags, rx_too_short,
        input  ready
    );
    modport sink (
        input  valid, action, jitter, rx_xid, rx_your_addr_set, rx_client_addr_set,
               rx_hw_type, rx_hw_len, rx_hw_addr, rx_tags, rx_too_short,
        output ready
    );
endinterface

interface bootp_crs_out_if;
    logic                                valid;
    logic                                ready;
    logic [bootp_crs_pkg::EV_W-1:0]      event_res;
    logic [bootp_crs_pkg::XID_W-1:0]     xid;
    logic [bootp_crs_pkg::SECS_W-1:0]    secs;
    logic [bootp_crs_pkg::ATT_W-1:0]     attempt;

    modport source (output valid, event_res, xid, secs, attempt, input ready);
    modport sink (input valid, event_res, xid, secs, attempt, output ready);
endinterface

interface bootp_crs_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [bootp_crs_pkg::CFG_IDX_W-1:0]    index;
    logic [bootp_crs_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bootp_crs_front.sv @@
`default_nettype none

module bootp_crs_front #(
    parameter int JITTER_TICKS = 10,
    parameter int TAG_COUNT    = 3
) (
    bootp_crs_in_if.sink          i_in,
    input  wire bootp_crs_pkg::t_cfg  i_cfg,
    input  wire                   i_full,
    output logic                  o_push,
    output bootp_crs_pkg::t_item  o_item
);

    localparam logic [bootp_crs_pkg::TAG_W-1:0] WANTED =
        (TAG_COUNT >= 3) ? 3'b111 : bootp_crs_pkg::TAG_W'((1 << TAG_COUNT) - 1);

    logic signed [7:0]                      w_jx;
    logic signed [7:0]                      w_jmax;
    logic signed [7:0]                      w_jcl;
    logic [bootp_crs_pkg::HW_BYTES-1:0]     w_byte_ok;
    logic [bootp_crs_pkg::TAG_W-1:0]        w_tags;

    // accept whenever the queue has room
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // clamp jitter to the allowed span
    always_comb begin
        w_jx   = {{3{i_in.jitter[bootp_crs_pkg::JIT_W-1]}}, i_in.jitter};
        w_jmax = $signed(8'(JITTER_TICKS));
        if (w_jx > w_jmax) begin
            w_jcl = w_jmax;
        end else if (w_jx < -w_jmax) begin
            w_jcl = -w_jmax;
        end else begin
            w_jcl = w_jx;
        end
    end

    // hardware address compare, low bytes first, only the first hw_len bytes
    always_comb begin
        for (int b = 0; b < bootp_crs_pkg::HW_BYTES; b++) begin
            w_byte_ok[b] = (i_in.rx_hw_addr[8*b +: 8] == i_cfg.hw_addr[8*b +: 8])
                        || (bootp_crs_pkg::HWL_W'(b) >= i_cfg.hw_len);
        end
    end

    assign w_tags = i_in.rx_tags & WANTED;

    // classify the request
    always_comb begin
        o_item.jitter    = w_jcl[bootp_crs_pkg::JIT_W-1:0];
        o_item.rx_xid    = i_in.rx_xid;
        o_item.fields_ok = (i_in.rx_your_addr_set || i_in.rx_client_addr_set)
                        && (i_in.rx_hw_type == i_cfg.hw_type)
                        && (i_in.rx_hw_len == {5'b0, i_cfg.hw_len})
                        && (&w_byte_ok);
        o_item.tags      = w_tags;
        o_item.complete  = ($countones(w_tags) == TAG_COUNT);
        unique case (bootp_crs_pkg::t_action'(i_in.action))
            bootp_crs_pkg::ACT_START: o_item.kind = bootp_crs_pkg::K_START;
            bootp_crs_pkg::ACT_TICK:  o_item.kind = bootp_crs_pkg::K_TICK;
            bootp_crs_pkg::ACT_REPLY: o_item.kind = i_in.rx_too_short ?
                                                    bootp_crs_pkg::K_NOP :
                                                    bootp_crs_pkg::K_REPLY;
            default:                  o_item.kind = bootp_crs_pkg::K_NOP;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/bootp_crs_queue.sv @@
`default_nettype none

module bootp_crs_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  wire bootp_crs_pkg::t_item i_item,
    input  wire                   i_pop,
    output logic                  o_valid,
    output logic                  o_full,
    output bootp_crs_pkg::t_item  o_item
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    bootp_crs_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0]       r_wr;
    logic [PTR_W-1:0]       r_rd;
    logic [PTR_W:0]         r_count;
    logic [PTR_W-1:0]       n_wr;
    logic [PTR_W-1:0]       n_rd;
    logic [PTR_W:0]         n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_item  = r_mem[r_rd];

    // pointer and fill update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bootp_crs_back.sv @@
`default_nettype none

module bootp_crs_back #(
    parameter int INITIAL_WAIT_TICKS = 40,
    parameter int MAX_WAIT_TICKS     = 640
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire bootp_crs_pkg::t_cfg  i_cfg,
    input  wire                       i_q_valid,
    input  wire bootp_crs_pkg::t_item i_item,
    output logic                      o_q_pop,
    input  wire                       i_out_ready,
    output logic                      o_out_valid,
    output bootp_crs_pkg::t_result    o_result
);

    localparam int WW = bootp_crs_pkg::WAIT_W;
    localparam int TW = bootp_crs_pkg::TICKS_W;
    localparam logic [WW-1:0] INIT_WAIT = WW'(INITIAL_WAIT_TICKS);
    localparam logic [WW:0]   MAX_WAIT  = (WW+1)'(MAX_WAIT_TICKS);

    bootp_crs_pkg::t_phase                  r_phase, n_phase;
    logic [bootp_crs_pkg::ATT_W-1:0]        r_attempt, n_attempt;
    logic [WW-1:0]                          r_wait, n_wait;
    logic [TW-1:0]                          r_ticks, n_ticks;
    logic [bootp_crs_pkg::GATHER_W-1:0]     r_gather, n_gather;
    logic                                   r_have, n_have;
    logic [bootp_crs_pkg::TAG_W-1:0]        r_saved, n_saved;
    logic [bootp_crs_pkg::XID_W-1:0]        r_xid, n_xid;
    logic [bootp_crs_pkg::SUB_W-1:0]        r_sub, n_sub;
    logic [bootp_crs_pkg::SECS_W-1:0]       r_secs, n_secs;
    logic                                   r_out_valid, n_out_valid;
    bootp_crs_pkg::t_result                 r_out, n_out;

    logic                                   w_step;
    logic                                   w_waiting;
    logic [TW-1:0]                          w_ticks_dec;
    logic [bootp_crs_pkg::GATHER_W-1:0]     w_gather_inc;
    logic [WW:0]                            w_dbl;
    logic [WW-1:0]                          w_dbl_cap;
    logic [WW-1:0]                          w_arm_wait;
    logic [TW-1:0]                          w_arm;
    logic                                   w_match;
    logic                                   w_retry;
    logic                                   w_save;
    bootp_crs_pkg::t_event                  w_event;

    // wait plus jitter, never below one tick
    function automatic logic [TW-1:0] f_arm(input logic [WW-1:0] wl,
                                            input logic signed [bootp_crs_pkg::JIT_W-1:0] j);
        logic signed [TW:0] t;
        t = $signed({2'b00, wl}) + {{(TW+1-bootp_crs_pkg::JIT_W){j[bootp_crs_pkg::JIT_W-1]}}, j};
        if (t < (TW+1)'(1)) begin
            t = (TW+1)'(1);
        end
        return t[TW-1:0];
    endfunction

    // one request per cycle whenever the result register frees up
    assign w_step    = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop   = w_step;
    assign w_waiting = (r_phase == bootp_crs_pkg::PH_WAIT);

    // shared arithmetic
    assign w_ticks_dec  = (r_ticks != '0) ? r_ticks - 1'b1 : r_ticks;
    assign w_gather_inc = (&r_gather) ? r_gather : r_gather + 1'b1;
    assign w_dbl        = {r_wait, 1'b0};
    assign w_dbl_cap    = (w_dbl >= MAX_WAIT) ? MAX_WAIT[WW-1:0] : w_dbl[WW-1:0];
    assign w_arm_wait   = (i_item.kind == bootp_crs_pkg::K_START) ? INIT_WAIT : w_dbl_cap;
    assign w_arm        = f_arm(w_arm_wait, i_item.jitter);
    assign w_match      = i_item.fields_ok && (i_item.rx_xid == r_xid);

    // decide the event for this request
    always_comb begin
        w_event = bootp_crs_pkg::EV_NONE;
        w_retry = 1'b0;
        w_save  = 1'b0;
        unique case (i_item.kind)
            bootp_crs_pkg::K_START: begin
                w_event = bootp_crs_pkg::EV_SEND;
            end
            bootp_crs_pkg::K_TICK: begin
                if (w_waiting) begin
                    priority if (r_have && (w_gather_inc >= i_cfg.gather_limit)) begin
                        w_event = bootp_crs_pkg::EV_DONE_ANSWERED;
                    end else if (w_ticks_dec != '0) begin
                        w_event = bootp_crs_pkg::EV_NONE;
                    end else if (r_attempt >= i_cfg.retry_limit) begin
                        w_event = r_have ? bootp_crs_pkg::EV_DONE_ANSWERED :
                                           bootp_crs_pkg::EV_DONE_TIMEOUT;
                    end else begin
                        w_event = bootp_crs_pkg::EV_SEND;
                        w_retry = 1'b1;
                    end
                end
            end
            bootp_crs_pkg::K_REPLY: begin
                if (w_waiting && w_match) begin
                    if (!r_have || ((i_item.tags & ~r_saved) != '0)) begin
                        w_save = 1'b1;
                    end
                    if (i_item.complete) begin
                        w_event = bootp_crs_pkg::EV_DONE_ANSWERED;
                    end else if (!r_have || ((i_item.tags & ~r_saved) != '0)) begin
                        w_event = bootp_crs_pkg::EV_KEPT;
                    end
                end
            end
            default: begin
                w_event = bootp_crs_pkg::EV_NONE;
            end
        endcase
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_step) begin
            if (i_item.kind == bootp_crs_pkg::K_START) begin
                n_phase = bootp_crs_pkg::PH_WAIT;
            end else if (w_event == bootp_crs_pkg::EV_DONE_ANSWERED ||
                         w_event == bootp_crs_pkg::EV_DONE_TIMEOUT) begin
                n_phase = bootp_crs_pkg::PH_DONE;
            end
        end
    end

    // exchange counters
    always_comb begin
        n_attempt = r_attempt;
        n_wait    = r_wait;
        n_ticks   = r_ticks;
        n_gather  = r_gather;
        n_have    = r_have;
        n_saved   = r_saved;
        n_xid     = r_xid;
        n_sub     = r_sub;
        n_secs    = r_secs;
        if (w_step) begin
            if (i_item.kind == bootp_crs_pkg::K_START) begin
                n_attempt = '0;
                n_wait    = INIT_WAIT;
                n_ticks   = w_arm;
                n_gather  = '0;
                n_have    = 1'b0;
                n_saved   = '0;
                n_xid     = i_cfg.xid_start;
                n_sub     = '0;
                n_secs    = '0;
            end else if (i_item.kind == bootp_crs_pkg::K_TICK && w_waiting) begin
                if (r_sub == bootp_crs_pkg::SUB_LAST) begin
                    n_sub  = '0;
                    n_secs = (&r_secs) ? r_secs : r_secs + 1'b1;
                end else begin
                    n_sub = r_sub + 1'b1;
                end
                n_ticks = w_ticks_dec;
                if (r_have) begin
                    n_gather = w_gather_inc;
                end
                if (w_retry) begin
                    n_wait    = w_dbl_cap;
                    n_xid     = r_xid + 1'b1;
                    n_attempt = r_attempt + 1'b1;
                    n_ticks   = w_arm;
                end
            end
            if (w_save) begin
                n_have  = 1'b1;
                n_saved = i_item.tags;
            end
        end
    end

    // result register
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (w_step) begin
            n_out_valid     = 1'b1;
            n_out.event_res = w_event;
            if (w_event == bootp_crs_pkg::EV_NONE) begin
                n_out.xid     = '0;
                n_out.secs    = '0;
                n_out.attempt = '0;
            end else begin
                n_out.xid     = n_xid;
                n_out.secs    = n_secs;
                n_out.attempt = n_attempt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= bootp_crs_pkg::PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_attempt <= n_attempt;
        r_wait    <= n_wait;
        r_ticks   <= n_ticks;
        r_gather  <= n_gather;
        r_have    <= n_have;
        r_saved   <= n_saved;
        r_xid     <= n_xid;
        r_sub     <= n_sub;
        r_secs    <= n_secs;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/bootp_client_retry_and_reply_select_top.sv @@
`default_nettype none

// BOOTP client exchange sequencer. Each request on i_in is a start, a 100 ms
// tick or a parsed reply, and yields exactly one result on o_out: an event code
// (nothing, send request, reply kept, done answered, done timeout) with the
// current transaction id, whole seconds since start and send index. The block
// takes one request per clock cycle sustained while o_out is ready; an
// accepted request passes through the queue before its result is registered.
// A front stage classifies requests (jitter clamp, address and field
// compares, tag mask) into a two-entry queue; the back stage updates the
// exchange state once per request and holds the result in an output register,
// so up to two more requests are taken while a result waits. Registers are
// written through i_cfg, which is always ready, and should be changed only
// while no request is in flight.
module bootp_client_retry_and_reply_select_top #(
    parameter int INITIAL_WAIT_TICKS = 40,
    parameter int MAX_WAIT_TICKS     = 640,
    parameter int JITTER_TICKS       = 10,
    parameter int TAG_COUNT          = 3
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    bootp_crs_in_if.sink     i_in,
    bootp_crs_out_if.source  o_out,
    bootp_crs_cfg_if.sink    i_cfg
);

    bootp_crs_pkg::t_cfg     r_cfg;
    bootp_crs_pkg::t_item    w_front_item;
    bootp_crs_pkg::t_item    w_q_item;
    bootp_crs_pkg::t_result  w_result;
    logic                    w_push;
    logic                    w_pop;
    logic                    w_q_valid;
    logic                    w_q_full;
    logic                    w_out_valid;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hw_type      <= 8'd1;
            r_cfg.hw_len       <= 3'd6;
            r_cfg.hw_addr      <= '0;
            r_cfg.retry_limit  <= 8'd3;
            r_cfg.gather_limit <= 16'd20;
            r_cfg.xid_start    <= '0;
        end else if (i_cfg.valid) begin
            unique case (bootp_crs_pkg::t_cfg_idx'(i_cfg.index))
                bootp_crs_pkg::CFG_HW_TYPE:      r_cfg.hw_type      <= i_cfg.data[7:0];
                bootp_crs_pkg::CFG_HW_LEN:       r_cfg.hw_len       <= i_cfg.data[2:0];
                bootp_crs_pkg::CFG_HW_ADDR:      r_cfg.hw_addr      <= i_cfg.data[47:0];
                bootp_crs_pkg::CFG_RETRY_LIMIT:  r_cfg.retry_limit  <= i_cfg.data[7:0];
                bootp_crs_pkg::CFG_GATHER_LIMIT: r_cfg.gather_limit <= i_cfg.data[15:0];
                bootp_crs_pkg::CFG_XID_START:    r_cfg.xid_start    <= i_cfg.data[31:0];
                default: begin
                end
            endcase
        end
    end

    // request classification
    bootp_crs_front #(
        .JITTER_TICKS (JITTER_TICKS),
        .TAG_COUNT    (TAG_COUNT)
    ) u_front (
        .i_in   (i_in),
        .i_cfg  (r_cfg),
        .i_full (w_q_full),
        .o_push (w_push),
        .o_item (w_front_item)
    );

    // decoupling queue
    bootp_crs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_item  (w_q_item)
    );

    // exchange state and result register
    bootp_crs_back #(
        .INITIAL_WAIT_TICKS (INITIAL_WAIT_TICKS),
        .MAX_WAIT_TICKS     (MAX_WAIT_TICKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_item      (w_q_item),
        .o_q_pop     (w_pop),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_result    (w_result)
    );

    assign o_out.valid     = w_out_valid;
    assign o_out.event_res = w_result.event_res;
    assign o_out.xid       = w_result.xid;
    assign o_out.secs      = w_result.secs;
    assign o_out.attempt   = w_result.attempt;

endmodule

`default_nettype wire

@@ hw/rtl/bootp_crs_chk.sv @@
`default_nettype none

module bootp_crs_chk (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  i_out_valid,
    input wire                                  i_out_ready,
    input wire [bootp_crs_pkg::EV_W-1:0]        i_event_res,
    input wire [bootp_crs_pkg::XID_W-1:0]       i_xid,
    input wire [bootp_crs_pkg::SECS_W-1:0]      i_secs,
    input wire [bootp_crs_pkg::ATT_W-1:0]       i_attempt
);

    // result channel empties during reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_event_res) && $stable(i_xid)
            && $stable(i_secs) && $stable(i_attempt))
        else $error("stalled result changed");

    // no event means an all-zero result
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_res == bootp_crs_pkg::EV_NONE |->
            i_xid == '0 && i_secs == '0 && i_attempt == '0)
        else $error("empty event carries data");

    // event code stays within the defined set
    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_event_res <= bootp_crs_pkg::EV_DONE_TIMEOUT)
        else $error("undefined event code");

    // the first send of an exchange goes out at zero seconds
    a_first_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_res == bootp_crs_pkg::EV_SEND && i_attempt == '0
            |-> i_secs == '0)
        else $error("first send with nonzero seconds");

endmodule

bind bootp_client_retry_and_reply_select_top bootp_crs_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_event_res (o_out.event_res),
    .i_xid       (o_out.xid),
    .i_secs      (o_out.secs),
    .i_attempt   (o_out.attempt)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int JIT_W      = bootp_crs_pkg::JIT_W;
    localparam int XID_W      = bootp_crs_pkg::XID_W;
    localparam int HWT_W      = bootp_crs_pkg::HWT_W;
    localparam int HWL_W      = bootp_crs_pkg::HWL_W;
    localparam int RX_HWL_W   = bootp_crs_pkg::RX_HWL_W;
    localparam int ADDR_W     = bootp_crs_pkg::ADDR_W;
    localparam int HW_BYTES   = bootp_crs_pkg::HW_BYTES;
    localparam int TAG_W      = bootp_crs_pkg::TAG_W;
    localparam int SECS_W     = bootp_crs_pkg::SECS_W;
    localparam int ATT_W      = bootp_crs_pkg::ATT_W;
    localparam int GATHER_W   = bootp_crs_pkg::GATHER_W;
    localparam int WAIT_W     = bootp_crs_pkg::WAIT_W;
    localparam int TICKS_W    = bootp_crs_pkg::TICKS_W;
    localparam int CFG_DATA_W = bootp_crs_pkg::CFG_DATA_W;

    localparam int INITIAL_WAIT_TICKS = 40;
    localparam int MAX_WAIT_TICKS     = 640;
    localparam int JITTER_TICKS       = 10;
    localparam int TAG_COUNT          = 3;
    localparam int TICKS_IN_SEC       = 10;
    localparam int ELAPSED_W          = 20;
    localparam logic [TAG_W-1:0] WANTED_TAGS =
        (TAG_COUNT >= 3) ? 3'b111 : TAG_W'((1 << TAG_COUNT) - 1);

    localparam int RANDOM_ITEMS  = 400;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 30;

    // one request as the sender sees it
    typedef struct {
        bootp_crs_pkg::t_action   action;
        logic signed [JIT_W-1:0]  jitter;
        logic [XID_W-1:0]         rx_xid;
        logic                     your_set;
        logic                     client_set;
        logic [HWT_W-1:0]         hw_type;
        logic [RX_HWL_W-1:0]      hw_len;
        logic [ADDR_W-1:0]        hw_addr;
        logic [TAG_W-1:0]         tags;
        logic                     too_short;
    } t_request;

    // mirror of the exchange state plus the queue of events still owed
    class t_exchange_scoreboard;
        bootp_crs_pkg::t_cfg     regs;
        bootp_crs_pkg::t_phase   phase;
        logic [ATT_W-1:0]        attempts;
        logic [WAIT_W-1:0]       wait_len;
        logic [TICKS_W-1:0]      ticks_left;
        logic [GATHER_W-1:0]     gathered;
        logic                    have_saved;
        logic [TAG_W-1:0]        saved_tags;
        logic [XID_W-1:0]        cur_xid;
        logic [ELAPSED_W-1:0]    elapsed;
        bootp_crs_pkg::t_result  expected_events[$];
        int                      errors;

        function new();
            regs.hw_type      = 8'd1;
            regs.hw_len       = 3'd6;
            regs.hw_addr      = '0;
            regs.retry_limit  = 8'd3;
            regs.gather_limit = 16'd20;
            regs.xid_start    = '0;
            phase      = bootp_crs_pkg::PH_IDLE;
            attempts   = '0;
            wait_len   = WAIT_W'(INITIAL_WAIT_TICKS);
            ticks_left = '0;
            gathered   = '0;
            have_saved = 1'b0;
            saved_tags = '0;
            cur_xid    = '0;
            elapsed    = '0;
            errors     = 0;
        endfunction

        function void load_register(bootp_crs_pkg::t_cfg_idx idx,
                                    logic [CFG_DATA_W-1:0] d);
            case (idx)
                bootp_crs_pkg::CFG_HW_TYPE:      regs.hw_type      = d[HWT_W-1:0];
                bootp_crs_pkg::CFG_HW_LEN:       regs.hw_len       = d[HWL_W-1:0];
                bootp_crs_pkg::CFG_HW_ADDR:      regs.hw_addr      = d[ADDR_W-1:0];
                bootp_crs_pkg::CFG_RETRY_LIMIT:  regs.retry_limit  = d[ATT_W-1:0];
                bootp_crs_pkg::CFG_GATHER_LIMIT: regs.gather_limit = d[GATHER_W-1:0];
                bootp_crs_pkg::CFG_XID_START:    regs.xid_start    = d[XID_W-1:0];
                default: ;
            endcase
        endfunction

        // address bytes that take part in the compare, low bytes first
        function logic [ADDR_W-1:0] addr_mask();
            int nbytes;
            nbytes = (regs.hw_len > HW_BYTES) ? HW_BYTES : int'(regs.hw_len);
            if (nbytes == 0) return '0;
            return {ADDR_W{1'b1}} >> (8 * (HW_BYTES - nbytes));
        endfunction

        // load the countdown with clamped jitter, never below one tick
        function void arm_wait(logic signed [JIT_W-1:0] jit);
            int j;
            int t;
            j = jit;
            if (j > JITTER_TICKS) j = JITTER_TICKS;
            if (j < -JITTER_TICKS) j = -JITTER_TICKS;
            t = int'(wait_len) + j;
            if (t < 1) t = 1;
            ticks_left = TICKS_W'(t);
        endfunction

        function bootp_crs_pkg::t_event advance(t_request r);
            logic [TAG_W-1:0] tags;
            int               w;
            bit               hit;
            bit               complete;
            // start restarts the exchange from any phase
            if (r.action == bootp_crs_pkg::ACT_START) begin
                phase      = bootp_crs_pkg::PH_WAIT;
                attempts   = '0;
                wait_len   = WAIT_W'(INITIAL_WAIT_TICKS);
                gathered   = '0;
                have_saved = 1'b0;
                saved_tags = '0;
                cur_xid    = regs.xid_start;
                elapsed    = '0;
                arm_wait(r.jitter);
                return bootp_crs_pkg::EV_SEND;
            end
            if (phase != bootp_crs_pkg::PH_WAIT) return bootp_crs_pkg::EV_NONE;
            // tick: gather window first, then wait expiry
            if (r.action == bootp_crs_pkg::ACT_TICK) begin
                if (elapsed != '1) elapsed++;
                if (ticks_left != 0) ticks_left--;
                if (have_saved) begin
                    if (gathered != '1) gathered++;
                    if (gathered >= regs.gather_limit) begin
                        phase = bootp_crs_pkg::PH_DONE;
                        return bootp_crs_pkg::EV_DONE_ANSWERED;
                    end
                end
                if (ticks_left != 0) return bootp_crs_pkg::EV_NONE;
                if (attempts >= regs.retry_limit) begin
                    phase = bootp_crs_pkg::PH_DONE;
                    return have_saved ? bootp_crs_pkg::EV_DONE_ANSWERED
                                      : bootp_crs_pkg::EV_DONE_TIMEOUT;
                end
                w = 2 * int'(wait_len);
                if (w >= MAX_WAIT_TICKS) w = MAX_WAIT_TICKS;
                wait_len = WAIT_W'(w);
                cur_xid++;
                attempts++;
                arm_wait(r.jitter);
                return bootp_crs_pkg::EV_SEND;
            end
            if (r.action != bootp_crs_pkg::ACT_REPLY || r.too_short)
                return bootp_crs_pkg::EV_NONE;
            // reply selection
            hit = (r.rx_xid == cur_xid) && (r.your_set || r.client_set)
                && (r.hw_type == regs.hw_type)
                && (r.hw_len == RX_HWL_W'(regs.hw_len))
                && (((r.hw_addr ^ regs.hw_addr) & addr_mask()) == '0);
            if (!hit) return bootp_crs_pkg::EV_NONE;
            tags     = r.tags & WANTED_TAGS;
            complete = ($countones(tags) == TAG_COUNT);
            if (!have_saved || (tags & ~saved_tags) != '0) begin
                have_saved = 1'b1;
                saved_tags = tags;
                if (!complete) return bootp_crs_pkg::EV_KEPT;
            end
            if (complete) begin
                phase = bootp_crs_pkg::PH_DONE;
                return bootp_crs_pkg::EV_DONE_ANSWERED;
            end
            return bootp_crs_pkg::EV_NONE;
        endfunction

        function void take_request(t_request r);
            bootp_crs_pkg::t_event  ev;
            bootp_crs_pkg::t_result e;
            int                     s;
            ev = advance(r);
            e  = '0;
            e.event_res = ev;
            if (ev != bootp_crs_pkg::EV_NONE) begin
                s = int'(elapsed) / TICKS_IN_SEC;
                e.xid     = cur_xid;
                e.secs    = (s > 16'hFFFF) ? 16'hFFFF : SECS_W'(s);
                e.attempt = attempts;
            end
            expected_events.push_back(e);
        endfunction

        function void check_event(bootp_crs_pkg::t_result got);
            bootp_crs_pkg::t_result want;
            if (expected_events.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected result ev=%0d xid=%h, none expected",
                             $time, got.event_res, got.xid);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            if (got !== want) begin
                if (errors < MAX_REPORTS)
                    $display({"%0t: mismatch expected ev=%0d xid=%h secs=%0d att=%0d",
                              " actual ev=%0d xid=%h secs=%0d att=%0d"},
                             $time, want.event_res, want.xid, want.secs, want.attempt,
                             got.event_res, got.xid, got.secs, got.attempt);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bootp_crs_in_if  req_ch ();
    bootp_crs_out_if evt_ch ();
    bootp_crs_cfg_if cfg_ch ();

    t_exchange_scoreboard sb = new();
    bit calm;
    int requests_sent;
    int quiet_cycles;

    bootp_client_retry_and_reply_select_top #(
        .INITIAL_WAIT_TICKS (INITIAL_WAIT_TICKS),
        .MAX_WAIT_TICKS     (MAX_WAIT_TICKS),
        .JITTER_TICKS       (JITTER_TICKS),
        .TAG_COUNT          (TAG_COUNT)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (evt_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones, none in calm stretches
    function automatic int pick_gap();
        int p;
        if (calm) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure
    initial begin
        int n;
        evt_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                evt_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            evt_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // result check and watchdog on lack of progress
    always @(posedge i_clk) begin
        if (evt_ch.valid && evt_ch.ready)
            sb.check_event(bootp_crs_pkg::t_result'({evt_ch.event_res, evt_ch.xid,
                                                     evt_ch.secs, evt_ch.attempt}));
        if ((evt_ch.valid && evt_ch.ready) || (req_ch.valid && req_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic t_request any_request(bootp_crs_pkg::t_action a);
        t_request r;
        r.action     = a;
        r.jitter     = ($urandom_range(0, 3) == 0) ? JIT_W'($urandom_range(0, 31))
                                                   : JIT_W'(int'($urandom_range(0, 20)) - 10);
        r.rx_xid     = $urandom;
        r.your_set   = 1'($urandom_range(0, 1));
        r.client_set = 1'($urandom_range(0, 1));
        r.hw_type    = HWT_W'($urandom);
        r.hw_len     = RX_HWL_W'($urandom);
        r.hw_addr    = ADDR_W'({$urandom, $urandom});
        r.tags       = TAG_W'($urandom_range(0, 7));
        r.too_short  = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // reply that matches the current exchange; unused address bytes stay random
    function automatic t_request good_reply(logic [TAG_W-1:0] tags);
        t_request          r;
        logic [ADDR_W-1:0] m;
        r = any_request(bootp_crs_pkg::ACT_REPLY);
        m = sb.addr_mask();
        r.rx_xid  = sb.cur_xid;
        if (!r.your_set && !r.client_set) r.your_set = 1'b1;
        r.hw_type = sb.regs.hw_type;
        r.hw_len  = RX_HWL_W'(sb.regs.hw_len);
        r.hw_addr = (r.hw_addr & ~m) | (sb.regs.hw_addr & m);
        r.tags    = tags;
        r.too_short = 1'b0;
        return r;
    endfunction

    // reply with one flaw that keeps it from matching
    function automatic t_request bad_reply();
        t_request r;
        int nbytes;
        r = good_reply(TAG_W'($urandom_range(0, 7)));
        nbytes = (sb.regs.hw_len > HW_BYTES) ? HW_BYTES : int'(sb.regs.hw_len);
        case ($urandom_range(0, 6))
            0: r.rx_xid = r.rx_xid ^ (32'd1 << $urandom_range(0, 31));
            1: begin
                r.your_set   = 1'b0;
                r.client_set = 1'b0;
            end
            2: r.hw_type = r.hw_type ^ HWT_W'($urandom_range(1, 255));
            3: r.hw_len  = r.hw_len ^ RX_HWL_W'($urandom_range(1, 255));
            4: begin
                if (nbytes > 0)
                    r.hw_addr[8 * $urandom_range(0, nbytes - 1) + $urandom_range(0, 7)] ^= 1'b1;
                else
                    r.rx_xid = ~r.rx_xid;
            end
            5: r.too_short = 1'b1;
            default: r = any_request(bootp_crs_pkg::ACT_REPLY);
        endcase
        return r;
    endfunction

    task automatic send_request(t_request r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid              <= 1'b1;
        req_ch.action             <= r.action;
        req_ch.jitter             <= r.jitter;
        req_ch.rx_xid             <= r.rx_xid;
        req_ch.rx_your_addr_set   <= r.your_set;
        req_ch.rx_client_addr_set <= r.client_set;
        req_ch.rx_hw_type         <= r.hw_type;
        req_ch.rx_hw_len          <= r.hw_len;
        req_ch.rx_hw_addr         <= r.hw_addr;
        req_ch.rx_tags            <= r.tags;
        req_ch.rx_too_short       <= r.too_short;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.take_request(r);
        requests_sent++;
    endtask

    // stop sending and wait for every owed result
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all six registers back to back, junk in unused data bits
    task automatic program_registers(bootp_crs_pkg::t_cfg c);
        logic [CFG_DATA_W-1:0] d;
        for (int k = bootp_crs_pkg::CFG_HW_TYPE; k <= bootp_crs_pkg::CFG_XID_START; k++) begin
            d = CFG_DATA_W'({$urandom, $urandom});
            case (bootp_crs_pkg::t_cfg_idx'(k))
                bootp_crs_pkg::CFG_HW_TYPE:      d[HWT_W-1:0]    = c.hw_type;
                bootp_crs_pkg::CFG_HW_LEN:       d[HWL_W-1:0]    = c.hw_len;
                bootp_crs_pkg::CFG_HW_ADDR:      d[ADDR_W-1:0]   = c.hw_addr;
                bootp_crs_pkg::CFG_RETRY_LIMIT:  d[ATT_W-1:0]    = c.retry_limit;
                bootp_crs_pkg::CFG_GATHER_LIMIT: d[GATHER_W-1:0] = c.gather_limit;
                default:                         d[XID_W-1:0]    = c.xid_start;
            endcase
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= bootp_crs_pkg::t_cfg_idx'(k);
            cfg_ch.data  <= d;
            do @(posedge i_clk); while (!cfg_ch.ready);
            sb.load_register(bootp_crs_pkg::t_cfg_idx'(k), d);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic bootp_crs_pkg::t_cfg pick_settings();
        bootp_crs_pkg::t_cfg c;
        int                  p;
        c.hw_type = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                                : HWT_W'($urandom);
        c.hw_len = HWL_W'($urandom_range(0, 7));
        p = $urandom_range(0, 5);
        c.hw_addr = (p == 0) ? '0 : (p == 1) ? '1 : ADDR_W'({$urandom, $urandom});
        p = $urandom_range(0, 9);
        c.retry_limit = (p < 7) ? ATT_W'($urandom_range(0, 2))
                      : (p < 9) ? ATT_W'($urandom_range(3, 4)) : 8'hFF;
        p = $urandom_range(0, 9);
        c.gather_limit = (p < 7) ? GATHER_W'($urandom_range(0, 25))
                       : (p < 9) ? GATHER_W'($urandom_range(0, 1)) : 16'hFFFF;
        c.xid_start = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom;
        return c;
    endfunction

    // one start followed by ticks and replies in a mix chosen by style
    task automatic run_exchange(int style, int max_steps, bit slow_jitter);
        t_request r;
        int steps;
        int pick;
        int t_good;
        int t_bad;
        int t_start;
        int t_unused;
        calm = ($urandom_range(0, 4) == 0);
        case (style)
            0: begin t_good = 4;  t_bad = 2;  t_start = 0; t_unused = 0; end
            1: begin t_good = 50; t_bad = 20; t_start = 3; t_unused = 2; end
            2: begin t_good = 0;  t_bad = 3;  t_start = 0; t_unused = 1; end
            3: begin t_good = 15; t_bad = 7;  t_start = 2; t_unused = 1; end
            default: begin t_good = 0; t_bad = 0; t_start = 0; t_unused = 0; end
        endcase
        r = any_request(bootp_crs_pkg::ACT_START);
        if (slow_jitter) r.jitter = JIT_W'(-16);
        send_request(r);
        steps = 0;
        while (sb.phase == bootp_crs_pkg::PH_WAIT && steps < max_steps) begin
            pick = $urandom_range(0, 99);
            if (style == 2 && !sb.have_saved && sb.ticks_left == 1)
                r = good_reply(TAG_W'($urandom_range(0, 7)));
            else if (pick < t_good)
                r = good_reply(TAG_W'($urandom_range(0, 7)));
            else if (pick < t_good + t_bad)
                r = bad_reply();
            else if (pick < t_good + t_bad + t_start)
                r = any_request(bootp_crs_pkg::ACT_START);
            else if (pick < t_good + t_bad + t_start + t_unused)
                r = any_request(bootp_crs_pkg::ACT_UNUSED);
            else
                r = any_request(bootp_crs_pkg::ACT_TICK);
            if (slow_jitter) r.jitter = JIT_W'(-16);
            send_request(r);
            steps++;
        end
        // stragglers after the exchange has finished
        repeat ($urandom_range(0, 2))
            send_request(any_request(bootp_crs_pkg::t_action'($urandom_range(1, 3))));
    endtask

    task automatic run_directed();
        t_request r;
        // anything but start is dropped while idle
        send_request(any_request(bootp_crs_pkg::ACT_TICK));
        send_request(any_request(bootp_crs_pkg::ACT_REPLY));
        send_request(any_request(bootp_crs_pkg::ACT_UNUSED));
        // jitter past both clamps; the second start restarts the exchange
        r = any_request(bootp_crs_pkg::ACT_START);
        r.jitter = JIT_W'(-16);
        send_request(r);
        r.jitter = JIT_W'(15);
        send_request(r);
        // replies that must be rejected
        r = good_reply(3'b001);
        r.too_short = 1'b1;
        send_request(r);
        r = good_reply(3'b001);
        r.your_set   = 1'b0;
        r.client_set = 1'b0;
        send_request(r);
        r = good_reply(3'b001);
        r.hw_type = ~r.hw_type;
        send_request(r);
        r = good_reply(3'b001);
        r.hw_len = 8'hFE;
        send_request(r);
        r = good_reply(3'b001);
        r.rx_xid = ~r.rx_xid;
        send_request(r);
        r = good_reply(3'b001);
        r.hw_addr[ADDR_W-1] = ~r.hw_addr[ADDR_W-1];
        send_request(r);
        // first match kept, same tags dropped, new tag replaces the saved set
        r = good_reply(3'b001);
        r.your_set   = 1'b0;
        r.client_set = 1'b1;
        send_request(r);
        send_request(good_reply(3'b001));
        send_request(good_reply(3'b010));
        send_request(any_request(bootp_crs_pkg::ACT_UNUSED));
        send_request(any_request(bootp_crs_pkg::ACT_TICK));
        send_request(good_reply(3'b111));
        // dropped once done
        send_request(any_request(bootp_crs_pkg::ACT_TICK));
        send_request(good_reply(3'b111));
        // complete first reply finishes at once
        send_request(any_request(bootp_crs_pkg::ACT_START));
        send_request(good_reply(3'b111));
    endtask

    initial begin
        bootp_crs_pkg::t_cfg c;
        int                  round;
        int                  random_start;
        i_rst_n <= 1'b0;
        req_ch.valid              <= 1'b0;
        req_ch.action             <= bootp_crs_pkg::ACT_START;
        req_ch.jitter             <= '0;
        req_ch.rx_xid             <= '0;
        req_ch.rx_your_addr_set   <= 1'b0;
        req_ch.rx_client_addr_set <= 1'b0;
        req_ch.rx_hw_type         <= '0;
        req_ch.rx_hw_len          <= '0;
        req_ch.rx_hw_addr         <= '0;
        req_ch.rx_tags            <= '0;
        req_ch.rx_too_short       <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= bootp_crs_pkg::CFG_HW_TYPE;
        cfg_ch.data  <= '0;
        calm = 1'b0;
        requests_sent = 0;
        quiet_cycles  = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed checks on the reset settings
        run_directed();
        settle();

        // low extremes: no retries, no gather window, empty address compare
        c = '{hw_type: 8'h00, hw_len: 3'd0, hw_addr: '0, retry_limit: 8'd0,
              gather_limit: 16'd0, xid_start: 32'd0};
        program_registers(c);
        for (int k = 0; k < 4; k++) run_exchange(k, 300, 1'b0);
        settle();

        // high extremes: identifier wraps on the first resend
        c = '{hw_type: 8'hFF, hw_len: 3'd7, hw_addr: '1, retry_limit: 8'hFF,
              gather_limit: 16'hFFFF, xid_start: 32'hFFFF_FFFF};
        program_registers(c);
        for (int k = 0; k < 4; k++) run_exchange(k, 60, 1'b0);
        settle();

        // long back-off run that reaches the wait cap and times out
        c = pick_settings();
        c.retry_limit = 8'd5;
        program_registers(c);
        run_exchange(4, 2600, 1'b1);
        settle();

        // random exchanges under changing settings
        random_start = requests_sent;
        round = 0;
        while (requests_sent < random_start + RANDOM_ITEMS) begin
            if (round % 4 == 0) begin
                settle();
                program_registers(pick_settings());
            end else if (round == 1 || $urandom_range(0, 5) == 0) begin
                settle();
            end
            run_exchange($urandom_range(0, 3), 300, 1'b0);
            round++;
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_events.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
